FILE: sv/sha1_pkg.sv
// ----------------------------------------------------------------------------
// sha1_pkg
// Shared types, constants and helper functions of the streaming SHA-1 engine.
// ----------------------------------------------------------------------------
package sha1_pkg;

  // One input transaction: an optional message byte and an end-of-message mark.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_present;
    logic       message_end;
  } item_t;

  // One output transaction: a single word of the 160-bit digest.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
  } digest_t;

  localparam int unsigned NumChain   = 5;
  localparam int unsigned BlockWords = 16;

  localparam logic [31:0] IV_H0 = 32'h67452301;
  localparam logic [31:0] IV_H1 = 32'hEFCDAB89;
  localparam logic [31:0] IV_H2 = 32'h98BADCFE;
  localparam logic [31:0] IV_H3 = 32'h10325476;
  localparam logic [31:0] IV_H4 = 32'hC3D2E1F0;

  localparam logic [31:0] K_CH   = 32'h5A827999;
  localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
  localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [6:0] ROUND_PAR1 = 7'd20;
  localparam logic [6:0] ROUND_MAJ  = 7'd40;
  localparam logic [6:0] ROUND_PAR2 = 7'd60;
  localparam logic [6:0] LAST_ROUND = 7'd79;

  localparam logic [5:0] LAST_POS  = 6'd63;
  localparam logic [5:0] LEN_POS   = 6'd56;
  localparam logic [3:0] LAST_WORD_IDX = 4'd15;
  localparam logic [3:0] LEN_HI_IDX    = 4'd14;
  localparam logic [2:0] LAST_DIGEST   = 3'd4;

  typedef enum logic [1:0] {PH_CH, PH_PAR1, PH_MAJ, PH_PAR2} phase_t;

  typedef enum logic [1:0] {SRC_PARTIAL, SRC_ZERO, SRC_LEN_HI, SRC_LEN_LO} pad_src_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_UPDATE, ST_PAD_FIRST, ST_PAD_FILL, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {CK_DATA, CK_PAD, CK_FINAL} comp_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       absorb;
    logic       start_comp;
    logic       round;
    phase_t     phase;
    logic       update;
    logic       pad_wr;
    logic [3:0] pad_idx;
    pad_src_t   pad_src;
    logic       restart;
    logic [2:0] out_idx;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] pos;
  } dp_status_t;

  function automatic logic [31:0] init_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0:    w = IV_H0;
      3'd1:    w = IV_H1;
      3'd2:    w = IV_H2;
      3'd3:    w = IV_H3;
      default: w = IV_H4;
    endcase
    return w;
  endfunction

  function automatic logic [31:0] rol1(input logic [31:0] x);
    return {x[30:0], x[31]};
  endfunction

  function automatic logic [31:0] rol5(input logic [31:0] x);
    return {x[26:0], x[31:27]};
  endfunction

  function automatic logic [31:0] rol30(input logic [31:0] x);
    return {x[1:0], x[31:2]};
  endfunction

endpackage

FILE: sv/sha1_dp.sv
// ----------------------------------------------------------------------------
// sha1_dp
// Datapath: byte packing, message schedule, round registers, chaining words.
// ----------------------------------------------------------------------------
module sha1_dp import sha1_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dp_cmd_t     cmd,
  input  logic [7:0]  byte_value,
  output dp_status_t  status,
  output logic [31:0] digest_word
);

  logic [31:0] chain [NumChain];
  logic [31:0] sched [BlockWords];
  logic [23:0] pack;
  logic [60:0] count;
  logic [31:0] a, b, c, d, e;

  logic [5:0]  pos;
  logic [31:0] f, k, w_new, temp, partial, pad_word;
  logic [63:0] bit_len;

  assign pos        = count[5:0];
  assign status.pos = pos;
  assign bit_len    = {count, 3'b000};

  // The buffer acts as a sliding window of the schedule: word 0 is W[t].
  assign w_new = rol1(sched[13] ^ sched[8] ^ sched[2] ^ sched[0]);

  always_comb begin
    case (cmd.phase)
      PH_CH: begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end
      PH_PAR1: begin
        f = b ^ c ^ d;
        k = K_PAR1;
      end
      PH_MAJ: begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end
      default: begin
        f = b ^ c ^ d;
        k = K_PAR2;
      end
    endcase
  end

  assign temp = rol5(a) + f + e + k + sched[0];

  // Bytes already held for the current word, then the pad byte, then zeros.
  assign partial = {pack, PAD_BYTE} << {(2'd3 - pos[1:0]), 3'b000};

  always_comb begin
    case (cmd.pad_src)
      SRC_PARTIAL: pad_word = partial;
      SRC_LEN_HI:  pad_word = bit_len[63:32];
      SRC_LEN_LO:  pad_word = bit_len[31:0];
      default:     pad_word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.absorb) begin
      pack <= {pack[15:0], byte_value};
      if (pos[1:0] == 2'b11) begin
        sched[pos[5:2]] <= {pack, byte_value};
      end
    end
    if (cmd.pad_wr) begin
      sched[cmd.pad_idx] <= pad_word;
    end
    if (cmd.round) begin
      for (int i = 0; i < BlockWords - 1; i++) begin
        sched[i] <= sched[i + 1];
      end
      sched[BlockWords - 1] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_comp) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
    end else if (cmd.round) begin
      e <= d;
      d <= c;
      c <= rol30(b);
      b <= a;
      a <= temp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      for (int i = 0; i < NumChain; i++) begin
        chain[i] <= init_word(3'(i));
      end
      count <= '0;
    end else begin
      if (cmd.absorb) begin
        count <= count + 61'd1;
      end
      if (cmd.update) begin
        chain[0] <= chain[0] + a;
        chain[1] <= chain[1] + b;
        chain[2] <= chain[2] + c;
        chain[3] <= chain[3] + d;
        chain[4] <= chain[4] + e;
      end
    end
  end

  assign digest_word = chain[cmd.out_idx];

endmodule

FILE: sv/sha1_ctrl.sv
// ----------------------------------------------------------------------------
// sha1_ctrl
// Controller: sequences absorption, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha1_ctrl import sha1_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       byte_present,
  input  logic       message_end,
  output logic       item_stall,
  output logic       digest_valid,
  input  logic       digest_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t     state, state_next;
  logic [6:0] round_cnt, round_next;
  logic [3:0] pad_ptr, ptr_next;
  logic       len_here, len_next;
  logic       end_pending, end_next;
  comp_kind_t kind, kind_next;
  logic [2:0] out_idx, idx_next;
  phase_t     phase;

  always_comb begin
    if (round_cnt < ROUND_PAR1) begin
      phase = PH_CH;
    end else if (round_cnt < ROUND_MAJ) begin
      phase = PH_PAR1;
    end else if (round_cnt < ROUND_PAR2) begin
      phase = PH_MAJ;
    end else begin
      phase = PH_PAR2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      round_cnt   <= '0;
      pad_ptr     <= '0;
      len_here    <= 1'b0;
      end_pending <= 1'b0;
      kind        <= CK_DATA;
      out_idx     <= '0;
    end else begin
      state       <= state_next;
      round_cnt   <= round_next;
      pad_ptr     <= ptr_next;
      len_here    <= len_next;
      end_pending <= end_next;
      kind        <= kind_next;
      out_idx     <= idx_next;
    end
  end

  always_comb begin
    state_next   = state;
    round_next   = round_cnt;
    ptr_next     = pad_ptr;
    len_next     = len_here;
    end_next     = end_pending;
    kind_next    = kind;
    idx_next     = out_idx;
    item_stall   = 1'b1;
    digest_valid = 1'b0;
    cmd          = '0;
    cmd.phase    = phase;
    cmd.pad_idx  = pad_ptr;
    cmd.pad_src  = SRC_ZERO;
    cmd.out_idx  = out_idx;

    case (state)
      ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          cmd.absorb = byte_present;
          if (byte_present && status.pos == LAST_POS) begin
            cmd.start_comp = 1'b1;
            round_next     = '0;
            kind_next      = CK_DATA;
            end_next       = message_end;
            state_next     = ST_ROUND;
          end else if (message_end) begin
            state_next = ST_PAD_FIRST;
          end
        end
      end

      ST_PAD_FIRST: begin
        cmd.pad_wr  = 1'b1;
        cmd.pad_idx = status.pos[5:2];
        cmd.pad_src = SRC_PARTIAL;
        len_next    = (status.pos < LEN_POS);
        if (status.pos[5:2] == LAST_WORD_IDX) begin
          cmd.start_comp = 1'b1;
          round_next     = '0;
          kind_next      = CK_PAD;
          state_next     = ST_ROUND;
        end else begin
          ptr_next   = status.pos[5:2] + 4'd1;
          state_next = ST_PAD_FILL;
        end
      end

      ST_PAD_FILL: begin
        cmd.pad_wr = 1'b1;
        if (len_here && pad_ptr == LEN_HI_IDX) begin
          cmd.pad_src = SRC_LEN_HI;
        end else if (len_here && pad_ptr == LAST_WORD_IDX) begin
          cmd.pad_src = SRC_LEN_LO;
        end
        if (pad_ptr == LAST_WORD_IDX) begin
          cmd.start_comp = 1'b1;
          round_next     = '0;
          kind_next      = len_here ? CK_FINAL : CK_PAD;
          state_next     = ST_ROUND;
        end else begin
          ptr_next = pad_ptr + 4'd1;
        end
      end

      ST_ROUND: begin
        cmd.round = 1'b1;
        if (round_cnt == LAST_ROUND) begin
          state_next = ST_UPDATE;
        end else begin
          round_next = round_cnt + 7'd1;
        end
      end

      ST_UPDATE: begin
        cmd.update = 1'b1;
        case (kind)
          CK_DATA: begin
            state_next = end_pending ? ST_PAD_FIRST : ST_IDLE;
          end
          CK_PAD: begin
            ptr_next   = '0;
            len_next   = 1'b1;
            state_next = ST_PAD_FILL;
          end
          CK_FINAL: begin
            idx_next   = '0;
            state_next = ST_EMIT;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_EMIT: begin
        digest_valid = 1'b1;
        if (!digest_stall) begin
          if (out_idx == LAST_DIGEST) begin
            cmd.restart = 1'b1;
            state_next  = ST_IDLE;
          end else begin
            idx_next = out_idx + 3'd1;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/sha1_hash_engine_unit.sv
// ----------------------------------------------------------------------------
// sha1_hash_engine_unit: byte-streaming SHA-1 engine, one message byte per transaction.
// A byte transaction is taken while idle; the 64th byte of a block starts its compression.
// Message end: padding, compression of each padded block (one or two), then 5 words.
// No input is taken during compression, which uses the single shared round unit.
// Reset (rst, synchronous) idles the controller, loads h0..h4 and zeros the byte count.
// ----------------------------------------------------------------------------
//
// The design is split into a controller state machine (sha1_ctrl) and a
// datapath (sha1_dp). They talk only through the dp_cmd_t command struct and
// the dp_status_t status struct.
//
// Data flow: incoming bytes are collected big-endian in a 24-bit packing
// register and written as whole words into a 16-word buffer. The buffer also
// serves as the message schedule window: during compression it shifts down by
// one word per round, word 0 being W[t] and the new word entering at the top.
// One round of the compression function runs each cycle, followed by an
// update step that adds the working variables into the chaining words.
//
// Padding is written one buffer word per cycle. The first padding word merges
// the held bytes with the 0x80 marker; the remaining words are zero, except
// words 14 and 15 of the last block, which carry the 64-bit bit length. When
// the marker lands at byte 56 or later, a second block is built and
// compressed.
//
// The five digest words are shown straight from the chaining registers, one
// transaction per word, h0 first. The engine accepts no new input while it
// compresses, pads or delivers the digest. After the last word is taken, the
// chaining words and the byte count return to their initial values.
module sha1_hash_engine_unit import sha1_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    digest_valid,
  input  logic    digest_stall,
  output digest_t digest
);

  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [31:0] digest_word;

  sha1_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .byte_present (item.byte_present),
    .message_end  (item.message_end),
    .item_stall   (item_stall),
    .digest_valid (digest_valid),
    .digest_stall (digest_stall),
    .status       (status),
    .cmd          (cmd)
  );

  sha1_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .byte_value  (item.byte_value),
    .status      (status),
    .digest_word (digest_word)
  );

  // The word index is held by the controller and stays stable while stalled.
  assign digest.digest_word = digest_word;
  assign digest.word_number = cmd.out_idx;
  assign digest.final_word  = (cmd.out_idx == LAST_DIGEST);

`ifndef SYNTHESIS
  // Input is only taken while no digest is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(digest_valid && !item_stall))
    else $error("input accepted while digest output is pending");

  // Taking the last digest word returns the engine to accepting input.
  a_final_to_idle: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && !digest_stall && digest.final_word)
    |=> (!item_stall && !digest_valid))
    else $error("engine did not return to idle after the last digest word");

  // Digest words follow each other without gaps in their numbering.
  a_word_order: assert property (@(posedge clk) disable iff (rst)
    (digest_valid && !digest_stall && !digest.final_word)
    |=> (digest_valid && digest.word_number == $past(digest.word_number) + 3'd1))
    else $error("digest words out of order");
`endif

endmodule
